// ===== sv/lcps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lcps_pkg;

   // command codes
   localparam logic [1:0] CMD_FUNCS = 2'd0;
   localparam logic [1:0] CMD_SPEED = 2'd1;
   localparam logic [1:0] CMD_ESTOP = 2'd2;
   localparam logic [1:0] CMD_BIN   = 2'd3;

   // decoder formats
   localparam logic [3:0] FMT_MA14       = 4'd0;
   localparam logic [3:0] FMT_MB14       = 4'd1;
   localparam logic [3:0] FMT_MB27_STEP  = 4'd2;
   localparam logic [3:0] FMT_MB27_PLAIN = 4'd3;
   localparam logic [3:0] FMT_DCC14      = 4'd4;
   localparam logic [3:0] FMT_DCC28      = 4'd5;
   localparam logic [3:0] FMT_DCC126     = 4'd6;
   localparam logic [3:0] FMT_DCCSDF     = 4'd7;
   localparam logic [3:0] FMT_M3         = 4'd8;

   // packet kinds
   localparam logic [4:0] K_SPEED     = 5'd0;
   localparam logic [4:0] K_ESTOP     = 5'd1;
   localparam logic [4:0] K_REV       = 5'd2;
   localparam logic [4:0] K_MM_F14    = 5'd3;
   localparam logic [4:0] K_MM_F1     = 5'd4;
   localparam logic [4:0] K_DCC_G0    = 5'd8;
   localparam logic [4:0] K_M3_F015   = 5'd14;
   localparam logic [4:0] K_M3_SINGLE = 5'd15;
   localparam logic [4:0] K_BIN       = 5'd16;

   localparam logic [7:0] DIR_BIT   = 8'h80;
   localparam logic [7:0] STEP_MASK = 8'h7F;

   localparam int SLOTS     = 17;
   localparam int SLOT_W    = 5;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int STATE_W   = 40;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } front_state_type;

   typedef enum logic [2:0] {
      MODE_MMF,
      MODE_MM2F,
      MODE_DCCF,
      MODE_M3F,
      MODE_MOTION,
      MODE_BIN
   } mode_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [9:0]  address;
      logic [3:0]  format;
      logic [31:0] new_funcs;
      logic [31:0] func_mask;
      logic [7:0]  speed_req;
      logic [14:0] bin_state;
      logic        bin_on;
   } req_type;

   typedef struct packed {
      logic [4:0]  packet_kind;
      logic [14:0] packet_value;
      logic        switch_on;
      logic        last;
   } rsp_type;

   // one command's packet plan, slots go out lowest first
   typedef struct packed {
      mode_type          mode;
      logic [SLOTS-1:0]  pend;
      logic [7:0]        dir_val;
      logic [7:0]        mid;
      logic [7:0]        spd;
      logic [14:0]       bs;
      logic              on;
   } desc_type;

endpackage
`default_nettype wire

// ===== sv/lcps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lcps_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== sv/lcps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lcps_front #(
   parameter int LOCO_SLOTS = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lcps_pkg::req_type req_data,
   output logic                   push,
   output lcps_pkg::desc_type     desc,
   input  wire logic              full
);
   import lcps_pkg::*;

   localparam int AW = $clog2(LOCO_SLOTS);

   front_state_type state_ff, state_in;
   req_type         item_ff, item_in;
   logic [AW-1:0]   clr_ff, clr_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [STATE_W-1:0] ram_wdata, ram_rdata, upd_word;

   logic        accept, addr_ok, exec_done;
   logic [7:0]  old_spd, spd, old2;
   logic [31:0] fb, ch;
   logic [6:0]  step, mx;
   logic        estop_due, dir_diff;
   logic [8:0]  spd_p1;
   desc_type    d;

   assign accept  = req_valid && !req_stall;
   assign addr_ok = (req_data.address != 10'd0) && (32'(req_data.address) < LOCO_SLOTS);

   lcps_ram #(.WIDTH(STATE_W), .DEPTH(LOCO_SLOTS)) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(AW'(item_ff.address)),
      .rdata(ram_rdata)
   );

   // command evaluation against the stored state
   always_comb begin
      old_spd  = ram_rdata[39:32];
      fb       = ram_rdata[31:0];
      ch       = (fb ^ item_ff.new_funcs) & item_ff.func_mask;
      case (item_ff.format) inside
         FMT_MA14, FMT_MB14, FMT_DCC14:         mx = 7'd14;
         FMT_MB27_STEP, FMT_MB27_PLAIN:         mx = 7'd27;
         FMT_DCC28:                             mx = 7'd28;
         FMT_DCC126, FMT_DCCSDF, FMT_M3:        mx = 7'd126;
         default:                               mx = 7'd0;
      endcase
      step      = (item_ff.speed_req[6:0] > mx) ? mx : item_ff.speed_req[6:0];
      spd       = {item_ff.speed_req[7], step};
      dir_diff  = old_spd[7] != spd[7];
      estop_due = ((old_spd & STEP_MASK) != 8'd0) && dir_diff;
      old2      = estop_due ? (old_spd & DIR_BIT) : old_spd;
      spd_p1    = {1'b0, spd} + 9'd1;

      d         = '0;
      d.dir_val = old_spd & DIR_BIT;
      d.spd     = old_spd;
      d.bs      = item_ff.bin_state;
      d.on      = item_ff.bin_on;
      upd_word  = ram_rdata;

      case (item_ff.cmd)
         CMD_FUNCS: begin
            upd_word[31:0] = (fb & ~ch) | (item_ff.new_funcs & ch);
            case (item_ff.format) inside
               FMT_MA14: begin
                  d.mode    = MODE_MMF;
                  d.pend[0] = ch[0];
                  d.pend[1] = |ch[4:1];
               end
               [FMT_MB14:FMT_MB27_PLAIN]: begin
                  d.mode      = MODE_MM2F;
                  d.pend[0]   = ch[0];
                  d.pend[4:1] = ch[4:1];
               end
               [FMT_DCC14:FMT_DCCSDF]: begin
                  d.mode = MODE_DCCF;
                  if (item_ff.format == FMT_DCC14) begin
                     d.pend[0] = ch[0];
                     d.pend[1] = |ch[4:1];
                  end else begin
                     d.pend[1] = |ch[4:0];
                  end
                  d.pend[2] = |ch[8:5];
                  d.pend[3] = |ch[12:9];
                  d.pend[4] = |ch[20:13];
                  d.pend[5] = |ch[28:21];
                  d.pend[6] = |ch[31:29];
               end
               FMT_M3: begin
                  d.mode       = MODE_M3F;
                  d.pend[0]    = |ch[15:0];
                  d.pend[16:1] = ch[31:16];
               end
               default: d.mode = MODE_MMF;
            endcase
         end
         CMD_SPEED: begin
            d.mode = MODE_MOTION;
            d.spd  = spd;
            if (spd != old_spd) begin
               upd_word[39:32] = spd;
               d.pend[3]       = 1'b1;
               if (item_ff.format == FMT_MB27_STEP) begin
                  d.pend[0] = estop_due;
                  if (step != 7'd0) begin
                     if (!spd[0]) begin
                        d.pend[2] = 1'b1;
                        d.mid     = spd_p1[7:0];
                     end else if (spd_p1 == {1'b0, old2}) begin
                        d.pend[2] = 1'b1;
                        d.mid     = spd - 8'd1;
                     end
                  end
               end else begin
                  d.pend[0] = estop_due;
                  d.pend[1] = !estop_due && dir_diff && (item_ff.format <= FMT_MB27_PLAIN);
               end
            end
         end
         CMD_ESTOP: begin
            d.mode          = MODE_MOTION;
            d.pend[0]       = 1'b1;
            upd_word[39:32] = old_spd & DIR_BIT;
         end
         default: begin
            d.mode    = MODE_BIN;
            d.pend[0] = item_ff.format inside {[FMT_DCC14:FMT_DCCSDF]};
         end
      endcase
   end

   assign exec_done = (state_ff == ST_EXEC) && ((d.pend == '0) || !full);
   assign desc      = d;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(LOCO_SLOTS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept && addr_ok) state_in = ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC:  if (exec_done) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = AW'(item_ff.address);
      ram_wdata = upd_word;
      push      = 1'b0;
      clr_in    = clr_ff;
      item_in   = accept ? req_data : item_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = {DIR_BIT, 32'd0};
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: req_stall = 1'b0;
         ST_EXEC: begin
            ram_we = exec_done;
            push   = exec_done && (d.pend != '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      item_ff <= item_in;
   end
endmodule
`default_nettype wire

// ===== sv/lcps_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lcps_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire lcps_pkg::desc_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output lcps_pkg::desc_type      pop_data,
   output logic                    empty
);
   import lcps_pkg::*;

   desc_type           entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_PTR_W:0]   cnt_ff, cnt_in;

   assign full     = cnt_ff == (Q_PTR_W + 1)'(Q_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ff + Q_PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ff + Q_PTR_W'(1);
      end
      if (push && !pop) cnt_in = cnt_ff + (Q_PTR_W + 1)'(1);
      else if (pop && !push) cnt_in = cnt_ff - (Q_PTR_W + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) entry_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ===== sv/lcps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lcps_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               empty,
   input  wire lcps_pkg::desc_type q_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output lcps_pkg::rsp_type       rsp_data
);
   import lcps_pkg::*;

   logic     busy_ff, busy_in, rv_ff, rv_in;
   desc_type cur_ff, cur_in;
   rsp_type  out_ff, out_in;

   logic [SLOT_W-1:0] idx;
   logic              found, out_free, fire;
   logic [SLOTS-1:0]  rest;
   rsp_type           pkt;

   // lowest pending slot
   always_comb begin
      idx   = '0;
      found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (cur_ff.pend[i] && !found) begin
            idx   = SLOT_W'(i);
            found = 1'b1;
         end
      end
      rest      = cur_ff.pend & ~(SLOTS'(1) << idx);
   end

   always_comb begin
      pkt           = '0;
      pkt.last      = rest == '0;
      case (cur_ff.mode)
         MODE_MMF: begin
            pkt.packet_kind  = (idx == '0) ? K_SPEED : K_MM_F14;
            pkt.packet_value = (idx == '0) ? 15'(cur_ff.spd) : 15'd0;
         end
         MODE_MM2F: begin
            pkt.packet_kind  = (idx == '0) ? K_SPEED : K_MM_F1 + idx - 5'd1;
            pkt.packet_value = 15'(cur_ff.spd);
         end
         MODE_DCCF: begin
            pkt.packet_kind  = (idx == '0) ? K_SPEED : K_DCC_G0 + idx - 5'd1;
            pkt.packet_value = (idx == '0) ? 15'(cur_ff.spd) : 15'd0;
         end
         MODE_M3F: begin
            pkt.packet_kind  = (idx == '0) ? K_M3_F015 : K_M3_SINGLE;
            pkt.packet_value = (idx == '0) ? 15'd0 : 15'(idx) + 15'd15;
         end
         MODE_MOTION: begin
            case (idx)
               5'd0: begin
                  pkt.packet_kind  = K_ESTOP;
                  pkt.packet_value = 15'(cur_ff.dir_val);
               end
               5'd1: begin
                  pkt.packet_kind  = K_REV;
                  pkt.packet_value = 15'(cur_ff.dir_val);
               end
               5'd2: begin
                  pkt.packet_kind  = K_SPEED;
                  pkt.packet_value = 15'(cur_ff.mid);
               end
               default: begin
                  pkt.packet_kind  = K_SPEED;
                  pkt.packet_value = 15'(cur_ff.spd);
               end
            endcase
         end
         default: begin
            pkt.packet_kind  = K_BIN;
            pkt.packet_value = cur_ff.bs;
            pkt.switch_on    = cur_ff.on;
         end
      endcase
   end

   assign out_free  = !rv_ff || !rsp_stall;
   assign fire      = busy_ff && out_free;
   assign pop       = !busy_ff && !empty;
   assign rsp_valid = rv_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      rv_in   = rv_ff && rsp_stall;
      out_in  = out_ff;
      if (pop) begin
         busy_in = 1'b1;
         cur_in  = q_data;
      end
      if (fire) begin
         rv_in       = 1'b1;
         out_in      = pkt;
         cur_in.pend = rest;
         busy_in     = rest != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rv_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rv_ff   <= rv_in;
      end
      cur_ff <= cur_in;
      out_ff <= out_in;
   end
endmodule
`default_nettype wire

// ===== sv/loco_command_packet_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Locomotive command scheduler: each accepted command with a valid address is
// checked against the per-address speed and function state and turned into
// an ordered run of track-packet requests, one per cycle on the rsp channel
// while rsp_stall allows, the final one flagged by last. After reset the
// state memory is swept to its reset contents, one address per cycle, and
// req_stall stays high meanwhile. A command then passes the front states for
// accept, state memory read, and evaluate and write back, and no new command
// is taken until it is done; a command with packets waits in evaluation while
// the plan queue is full. The back sequencer loads a plan, then sends one
// packet per cycle while rsp_stall allows, and loads the next plan only after
// the last packet. The rate is set by the state memory read-modify-write in
// the front and the one-packet-per-cycle sequencer. A two-entry plan queue
// lets the front run ahead while packets drain.
module loco_command_packet_scheduler_unit #(
   parameter int LOCO_SLOTS = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lcps_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lcps_pkg::rsp_type      rsp_data
);
   import lcps_pkg::*;

   logic     push, full, pop, empty;
   desc_type push_desc, pop_desc;

   lcps_front #(.LOCO_SLOTS(LOCO_SLOTS)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .push(push),
      .desc(push_desc),
      .full(full)
   );

   lcps_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_desc),
      .full(full),
      .pop(pop),
      .pop_data(pop_desc),
      .empty(empty)
   );

   lcps_back u_back (
      .clock(clock),
      .reset(reset),
      .empty(empty),
      .q_data(pop_desc),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import lcps_pkg::*;

   localparam int NUM_SLOTS = 1024;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   loco_command_packet_scheduler_unit #(.LOCO_SLOTS(NUM_SLOTS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   logic [7:0] speed_mem [NUM_SLOTS];
   logic [31:0] func_mem [NUM_SLOTS];
   rsp_type packet_q [$];
   rsp_type run_q [$];
   int errors = 0;
   int idle_pct = 18;
   int quiet_cycles = 0;

   function automatic int step_count(logic [3:0] fmt);
      case (fmt)
         FMT_MA14, FMT_MB14, FMT_DCC14: return 14;
         FMT_MB27_STEP, FMT_MB27_PLAIN: return 27;
         FMT_DCC28: return 28;
         FMT_DCC126, FMT_DCCSDF, FMT_M3: return 126;
         default: return 0;
      endcase
   endfunction

   task automatic add_packet(logic [4:0] kind, logic [14:0] value, logic on);
      rsp_type p;
      p.packet_kind = kind;
      p.packet_value = value;
      p.switch_on = on;
      p.last = 1'b0;
      if (run_q.size() < 17) run_q.push_back(p);
   endtask

   task automatic plan_funcs(int a, logic [3:0] fmt, logic [31:0] nf, logic [31:0] m);
      logic [31:0] ch;
      logic [7:0] sp;
      ch = (func_mem[a] & m) ^ (nf & m);
      sp = speed_mem[a];
      if (ch == 32'd0) return;
      func_mem[a] = (func_mem[a] & ~ch) | (nf & ch);
      if (fmt == FMT_MA14) begin
         if (ch[0]) add_packet(K_SPEED, 15'(sp), 1'b0);
         if (|ch[4:1]) add_packet(K_MM_F14, 15'd0, 1'b0);
      end else if (fmt <= FMT_MB27_PLAIN) begin
         if (ch[0]) add_packet(K_SPEED, 15'(sp), 1'b0);
         for (int f = 1; f <= 4; f++)
            if (ch[f]) add_packet(5'(K_MM_F1 + f - 1), 15'(sp), 1'b0);
      end else if (fmt <= FMT_DCCSDF) begin
         if (fmt == FMT_DCC14) begin
            if (ch[0]) add_packet(K_SPEED, 15'(sp), 1'b0);
            if (|ch[4:1]) add_packet(K_DCC_G0, 15'd0, 1'b0);
         end else if (|ch[4:0]) begin
            add_packet(K_DCC_G0, 15'd0, 1'b0);
         end
         if (|ch[8:5]) add_packet(K_DCC_G0 + 5'd1, 15'd0, 1'b0);
         if (|ch[12:9]) add_packet(K_DCC_G0 + 5'd2, 15'd0, 1'b0);
         if (|ch[20:13]) add_packet(K_DCC_G0 + 5'd3, 15'd0, 1'b0);
         if (|ch[28:21]) add_packet(K_DCC_G0 + 5'd4, 15'd0, 1'b0);
         if (|ch[31:29]) add_packet(K_DCC_G0 + 5'd5, 15'd0, 1'b0);
      end else if (fmt == FMT_M3) begin
         if (|ch[15:0]) add_packet(K_M3_F015, 15'd0, 1'b0);
         for (int f = 16; f < 32; f++)
            if (ch[f]) add_packet(K_M3_SINGLE, 15'(f), 1'b0);
      end
   endtask

   task automatic plan_speed(int a, logic [3:0] fmt, logic [7:0] req);
      int step;
      logic [7:0] spd, old;
      step = int'(req[6:0]);
      if (step > step_count(fmt)) step = step_count(fmt);
      spd = (req & DIR_BIT) | 8'(step);
      old = speed_mem[a];
      if (spd == old) return;
      if (fmt == FMT_MB27_STEP) begin
         if ((old & STEP_MASK) != 8'd0 && old[7] != spd[7]) begin
            add_packet(K_ESTOP, 15'(old & DIR_BIT), 1'b0);
            old = old & DIR_BIT;
         end
         if (step != 0) begin
            if (!spd[0]) add_packet(K_SPEED, 15'(spd + 8'd1), 1'b0);
            else if (spd + 8'd1 == old) add_packet(K_SPEED, 15'(spd - 8'd1), 1'b0);
         end
      end else begin
         if ((old & STEP_MASK) != 8'd0 && old[7] != spd[7])
            add_packet(K_ESTOP, 15'(old & DIR_BIT), 1'b0);
         else if (fmt <= FMT_MB27_PLAIN && old[7] != spd[7])
            add_packet(K_REV, 15'(old & DIR_BIT), 1'b0);
      end
      speed_mem[a] = spd;
      add_packet(K_SPEED, 15'(spd), 1'b0);
   endtask

   task automatic predict_packets(req_type r);
      int a;
      a = int'(r.address);
      run_q.delete();
      if (a == 0 || a >= NUM_SLOTS) return;
      case (r.cmd)
         CMD_FUNCS: plan_funcs(a, r.format, r.new_funcs, r.func_mask);
         CMD_SPEED: plan_speed(a, r.format, r.speed_req);
         CMD_ESTOP: begin
            speed_mem[a] = speed_mem[a] & DIR_BIT;
            add_packet(K_ESTOP, 15'(speed_mem[a]), 1'b0);
         end
         default: if (r.format >= FMT_DCC14 && r.format <= FMT_DCCSDF)
            add_packet(K_BIN, r.bin_state, r.bin_on);
      endcase
      if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
      foreach (run_q[i]) packet_q.push_back(run_q[i]);
   endtask

   task automatic send_cmd(req_type r);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_packets(r);
   endtask

   function automatic req_type rand_cmd(int addr_hi);
      req_type r;
      r.cmd = 2'($urandom_range(3));
      r.address = 10'($urandom_range(addr_hi, 1));
      if ($urandom_range(40) == 0) r.address = 10'd0;
      r.format = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      r.new_funcs = $urandom;
      r.func_mask = ($urandom_range(2) == 0) ? 32'hffff_ffff : ($urandom & $urandom);
      r.speed_req = 8'($urandom);
      if ($urandom_range(2) == 0) r.speed_req[6:0] = 7'($urandom_range(30));
      r.bin_state = 15'($urandom);
      r.bin_on = 1'($urandom);
      return r;
   endfunction

   function automatic req_type make_cmd(logic [1:0] c, int a, logic [3:0] f, logic [31:0] nf,
                                        logic [31:0] m, logic [7:0] s);
      req_type r;
      r = '0;
      r.cmd = c; r.address = 10'(a); r.format = f;
      r.new_funcs = nf; r.func_mask = m; r.speed_req = s;
      r.bin_state = 15'h7fff; r.bin_on = 1'b1;
      return r;
   endfunction

   // rsp side: random stalls and in-order compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (packet_q.size() == 0) begin
               $display("%0t unexpected packet: expected nothing actual %p", $time, rsp_data);
               errors++;
            end else begin
               if (rsp_data !== packet_q[0]) begin
                  $display("%0t packet mismatch: expected %p actual %p",
                           $time, packet_q[0], rsp_data);
                  errors++;
               end
               void'(packet_q.pop_front());
            end
         end
         rsp_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_directed();
      send_cmd(make_cmd(CMD_SPEED, 1, FMT_DCC126, 32'h0, 32'h0, 8'hff));
      send_cmd(make_cmd(CMD_SPEED, 1, FMT_DCC126, 32'h0, 32'h0, 8'h05));
      send_cmd(make_cmd(CMD_SPEED, 1, FMT_DCC126, 32'h0, 32'h0, 8'h05));
      send_cmd(make_cmd(CMD_SPEED, 2, FMT_MA14, 32'h0, 32'h0, 8'h00));
      send_cmd(make_cmd(CMD_SPEED, 2, FMT_MB14, 32'h0, 32'h0, 8'h8e));
      send_cmd(make_cmd(CMD_SPEED, 3, FMT_MB27_STEP, 32'h0, 32'h0, 8'h8a));
      send_cmd(make_cmd(CMD_SPEED, 3, FMT_MB27_STEP, 32'h0, 32'h0, 8'h89));
      send_cmd(make_cmd(CMD_SPEED, 3, FMT_MB27_STEP, 32'h0, 32'h0, 8'h04));
      send_cmd(make_cmd(CMD_SPEED, 4, 4'd15, 32'h0, 32'h0, 8'h20));
      send_cmd(make_cmd(CMD_ESTOP, 1023, 4'd12, 32'h0, 32'h0, 8'h00));
      send_cmd(make_cmd(CMD_ESTOP, 1, FMT_DCC28, 32'h0, 32'h0, 8'h00));
      send_cmd(make_cmd(CMD_FUNCS, 5, FMT_M3, 32'hffff_ffff, 32'hffff_ffff, 8'h00));
      send_cmd(make_cmd(CMD_FUNCS, 5, FMT_DCC14, 32'h0, 32'hffff_ffff, 8'h00));
      send_cmd(make_cmd(CMD_FUNCS, 5, FMT_DCC28, 32'hffff_ffff, 32'hffff_ffff, 8'h00));
      send_cmd(make_cmd(CMD_FUNCS, 5, FMT_MA14, 32'h0, 32'h1f, 8'h00));
      send_cmd(make_cmd(CMD_FUNCS, 5, FMT_MB27_PLAIN, 32'h1f, 32'h1f, 8'h00));
      send_cmd(make_cmd(CMD_FUNCS, 5, FMT_MB27_PLAIN, 32'h1f, 32'h1f, 8'h00));
      send_cmd(make_cmd(CMD_FUNCS, 6, 4'd9, 32'h1, 32'h1, 8'h00));
      send_cmd(make_cmd(CMD_BIN, 7, FMT_DCCSDF, 32'h0, 32'h0, 8'h00));
      send_cmd(make_cmd(CMD_BIN, 7, FMT_M3, 32'h0, 32'h0, 8'h00));
      send_cmd(make_cmd(CMD_SPEED, 0, FMT_DCC126, 32'h0, 32'h0, 8'h90));
   endtask

   task automatic test_random();
      // first a burst with no idling, then random idling, mostly on a small address pool
      idle_pct = 0;
      for (int i = 0; i < 60; i++) send_cmd(rand_cmd(8));
      idle_pct = 18;
      for (int i = 0; i < 190; i++) send_cmd(rand_cmd(($urandom_range(4) == 0) ? 1023 : 12));
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         speed_mem[i] = DIR_BIT;
         func_mem[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      req_valid <= 1'b0;
      while (packet_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0 && packet_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
